FILE: src/brf_pkg.sv
// Package for the byte ring FIFO: field widths, operation codes and the command word.
// Shared by brf_front, brf_back, the top level and the testbench; depends on nothing.
package brf_pkg;

	localparam int DataW    = 8;
	localparam int FieldW   = 10;
	localparam int CapW     = 11;
	localparam int MaxBurst = 64;
	localparam int BurstW   = $clog2(MaxBurst + 1);

	localparam logic [CapW-1:0] CapReset = 11'd1024;

	typedef enum logic [2:0] {
		OP_WRITE  = 3'd0,
		OP_READ   = 3'd1,
		OP_PEEK   = 3'd2,
		OP_DELETE = 3'd3,
		OP_CLEAR  = 3'd4
	} op_t;

	// One classified word, handed from front to back.
	typedef struct packed {
		logic              wr;
		logic              rd;
		logic [DataW-1:0]  wdata;
		logic              status;
		logic [FieldW-1:0] count;
		logic [FieldW-1:0] fill;
		logic [BurstW-1:0] nres;
	} cmd_t;

endpackage

FILE: src/byte_ring_fifo_with_peek.sv
// Top level of the byte ring FIFO with peek: front, word queue and back.
// Depends on brf_pkg, brf_front, brf_queue and brf_back.
//
// Write, read, delete, clear and unused op codes give one result each and may be
// accepted back to back; a peek gives one result per returned byte (at least one),
// since the back reads its single-port byte memory once per result. The first
// result of a word passes through a queue slot and the output register. The front
// keeps the pointers and fill level and classifies each word; a two-entry queue
// lets it run ahead of the back, so in_stall rises only while a peek burst or
// out_stall holds the back.
// The byte memory is not cleared after reset: only written entries are ever read.
// A write to the capacity register empties the ring.
module byte_ring_fifo_with_peek import brf_pkg::*; #(
	parameter int DEPTH = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CapW-1:0]   cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        op,
	input  logic [DataW-1:0]  data_in,
	input  logic [FieldW-1:0] offset,
	input  logic [FieldW-1:0] amount,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [DataW-1:0]  out_data,
	output logic              status,
	output logic [FieldW-1:0] out_count,
	output logic [FieldW-1:0] fill_level,
	output logic              last
);

	localparam int PW     = $clog2(DEPTH);
	localparam int LenMax = (DEPTH < 2047) ? DEPTH : 2047;
	localparam int LW     = $clog2(LenMax + 1);
	localparam int QW     = PW + $bits(cmd_t);

	logic          q_full, q_push, q_valid, q_pop;
	cmd_t          f_cmd, b_cmd;
	logic [PW-1:0] f_addr, b_addr;
	logic [LW-1:0] ring_len;
	logic [QW-1:0] q_dout;

	brf_front #(.DEPTH(DEPTH)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.op       (op),
		.data_in  (data_in),
		.offset   (offset),
		.amount   (amount),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (f_cmd),
		.q_addr   (f_addr),
		.ring_len (ring_len)
	);

	brf_queue #(.W(QW)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    ({f_addr, f_cmd}),
		.full   (q_full),
		.valid  (q_valid),
		.pop    (q_pop),
		.dout   (q_dout)
	);

	assign b_addr = q_dout[QW-1 -: PW];
	assign b_cmd  = cmd_t'(q_dout[$bits(cmd_t)-1:0]);

	brf_back #(.DEPTH(DEPTH)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.ring_len   (ring_len),
		.q_valid    (q_valid),
		.q_cmd      (b_cmd),
		.q_addr     (b_addr),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.status     (status),
		.out_count  (out_count),
		.fill_level (fill_level),
		.last       (last)
	);

`ifndef NO_ASSERTIONS
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

	a_burst_mid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |-> (!status && out_count != '0))
		else $error("non-final result outside a peek burst");

	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status) |-> (out_count == '0 && out_data == '0 && last))
		else $error("failed word carries data or count");
`endif

endmodule

FILE: src/brf_front.sv
// Front end of the byte ring FIFO: capacity register, pointers and fill level.
// Classifies each input word into a cmd_t; depends on brf_pkg.
module brf_front import brf_pkg::*; #(
	parameter int DEPTH = 1024
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic [CapW-1:0]                         cfg_data,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic [2:0]                              op,
	input  logic [DataW-1:0]                        data_in,
	input  logic [FieldW-1:0]                       offset,
	input  logic [FieldW-1:0]                       amount,
	input  logic                                    q_full,
	output logic                                    q_push,
	output cmd_t                                    q_cmd,
	output logic [$clog2(DEPTH)-1:0]                q_addr,
	output logic [$clog2((DEPTH < 2047 ? DEPTH : 2047) + 1)-1:0] ring_len
);

	localparam int PW     = $clog2(DEPTH);
	localparam int LenMax = (DEPTH < 2047) ? DEPTH : 2047;
	localparam int LW     = $clog2(LenMax + 1);
	localparam int AW     = ((PW > CapW) ? PW : CapW) + 1;

	logic [CapW-1:0] cap_q;
	logic [PW-1:0]   wp_q, rp_q, wp_n, rp_n;
	logic [LW-1:0]   fill_q, fill_n;
	logic [31:0]     len32;
	logic [AW-1:0]   len_a, fill_a, wp_a, rp_a, off_a, amt_a, nres_a, del_a;
	logic            accept;

	function automatic logic [AW-1:0] adv(input logic [AW-1:0] p, input logic [AW-1:0] n,
		input logic [AW-1:0] l);
		logic [AW-1:0] s;
		s = p + n;
		if (s >= l) begin
			s = s - l;
		end
		return s;
	endfunction

	always_comb begin
		if (cap_q < CapW'(2)) begin
			len32 = 32'd2;
		end else if (32'(cap_q) > 32'(DEPTH)) begin
			len32 = 32'(DEPTH);
		end else begin
			len32 = 32'(cap_q);
		end
	end

	assign ring_len = LW'(len32);
	assign len_a    = AW'(ring_len);
	assign fill_a   = AW'(fill_q);
	assign wp_a     = AW'(wp_q);
	assign rp_a     = AW'(rp_q);
	assign off_a    = AW'(offset);
	assign amt_a    = AW'(amount);

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign q_push   = accept;

	always_comb begin
		q_cmd      = '0;
		q_cmd.nres = BurstW'(1);
		q_addr     = wp_q;
		wp_n       = wp_q;
		rp_n       = rp_q;
		fill_n     = fill_q;
		nres_a     = '0;
		del_a      = '0;
		case (op_t'(op))
			OP_WRITE: begin
				if (fill_a == len_a - AW'(1)) begin
					q_cmd.status = 1'b1;
				end else begin
					q_cmd.wr    = 1'b1;
					q_cmd.wdata = data_in;
					wp_n        = PW'(adv(wp_a, AW'(1), len_a));
					fill_n      = fill_q + LW'(1);
				end
			end
			OP_READ: begin
				q_addr = rp_q;
				if (fill_q == '0) begin
					q_cmd.status = 1'b1;
				end else begin
					q_cmd.rd = 1'b1;
					rp_n     = PW'(adv(rp_a, AW'(1), len_a));
					fill_n   = fill_q - LW'(1);
				end
			end
			OP_PEEK: begin
				if (!(off_a >= fill_a || amount == '0)) begin
					nres_a = fill_a - off_a;
					if (amt_a < nres_a) begin
						nres_a = amt_a;
					end
					if (nres_a > AW'(MaxBurst)) begin
						nres_a = AW'(MaxBurst);
					end
					q_cmd.rd    = 1'b1;
					q_cmd.nres  = BurstW'(nres_a);
					q_cmd.count = FieldW'(nres_a);
					q_addr      = PW'(adv(rp_a, off_a, len_a));
				end
			end
			OP_DELETE: begin
				del_a       = (fill_a <= amt_a) ? fill_a : amt_a;
				rp_n        = PW'(adv(rp_a, del_a, len_a));
				fill_n      = fill_q - LW'(del_a);
				q_cmd.count = FieldW'(del_a);
			end
			OP_CLEAR: begin
				wp_n   = '0;
				rp_n   = '0;
				fill_n = '0;
			end
			default: begin
			end
		endcase
		q_cmd.fill = FieldW'(fill_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CapReset;
			wp_q   <= '0;
			rp_q   <= '0;
			fill_q <= '0;
		end else if (cfg_we) begin
			cap_q  <= cfg_data;
			wp_q   <= '0;
			rp_q   <= '0;
			fill_q <= '0;
		end else if (accept) begin
			wp_q   <= wp_n;
			rp_q   <= rp_n;
			fill_q <= fill_n;
		end
	end

endmodule

FILE: src/brf_queue.sv
// Two-entry word queue between the front and back of the byte ring FIFO.
// Generic over word width; depends on nothing.
module brf_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	output logic         valid,
	input  logic         pop,
	output logic [W-1:0] dout
);

	logic [W-1:0] slot_q [2];
	logic         wp_q, rp_q;
	logic [1:0]   cnt_q;
	logic         do_push;

	assign full    = (cnt_q == 2'd2);
	assign valid   = (cnt_q != 2'd0);
	assign dout    = slot_q[rp_q];
	assign do_push = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			if (do_push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!do_push && pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wp_q] <= din;
		end
	end

endmodule

FILE: src/brf_back.sv
// Back end of the byte ring FIFO: byte memory, peek burst sequencer, output register.
// Executes cmd_t words in order; depends on brf_pkg.
module brf_back import brf_pkg::*; #(
	parameter int DEPTH = 1024
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic [$clog2((DEPTH < 2047 ? DEPTH : 2047) + 1)-1:0] ring_len,
	input  logic                                    q_valid,
	input  cmd_t                                    q_cmd,
	input  logic [$clog2(DEPTH)-1:0]                q_addr,
	output logic                                    q_pop,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic [DataW-1:0]                        out_data,
	output logic                                    status,
	output logic [FieldW-1:0]                       out_count,
	output logic [FieldW-1:0]                       fill_level,
	output logic                                    last
);

	localparam int PW     = $clog2(DEPTH);
	localparam int LenMax = (DEPTH < 2047) ? DEPTH : 2047;
	localparam int LW     = $clog2(LenMax + 1);
	localparam int AW     = ((PW > LW) ? PW : LW) + 1;

	logic [DataW-1:0]  mem [DEPTH];
	logic [DataW-1:0]  rdata_q;

	logic              out_valid_q, burst_q;
	logic [PW-1:0]     b_addr_q;
	logic [BurstW-1:0] b_left_q;
	logic [FieldW-1:0] b_count_q, b_fill_q;
	logic              rd_q, status_q, last_q;
	logic [FieldW-1:0] count_q, fill_q;

	logic              src_wr, src_rd, src_status, src_last;
	logic [PW-1:0]     src_addr, next_addr;
	logic [DataW-1:0]  src_wdata;
	logic [FieldW-1:0] src_count, src_fill;
	logic [AW-1:0]     inc_a;
	logic              issue;

	always_comb begin
		if (burst_q) begin
			src_wr     = 1'b0;
			src_rd     = 1'b1;
			src_wdata  = '0;
			src_status = 1'b0;
			src_addr   = b_addr_q;
			src_count  = b_count_q;
			src_fill   = b_fill_q;
			src_last   = (b_left_q == BurstW'(1));
		end else begin
			src_wr     = q_cmd.wr;
			src_rd     = q_cmd.rd;
			src_wdata  = q_cmd.wdata;
			src_status = q_cmd.status;
			src_addr   = q_addr;
			src_count  = q_cmd.count;
			src_fill   = q_cmd.fill;
			src_last   = (q_cmd.nres <= BurstW'(1));
		end
	end

	// next byte of a peek, wrapping at the ring length
	assign inc_a     = AW'(src_addr) + AW'(1);
	assign next_addr = (inc_a == AW'(ring_len)) ? '0 : PW'(inc_a);

	assign issue = (!out_valid_q || !out_stall) && (burst_q || q_valid);
	assign q_pop = issue && !burst_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			burst_q     <= 1'b0;
		end else begin
			if (issue) begin
				out_valid_q <= 1'b1;
				burst_q     <= !src_last;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			b_addr_q <= next_addr;
			b_left_q <= burst_q ? (b_left_q - BurstW'(1)) : (q_cmd.nres - BurstW'(1));
			if (!burst_q) begin
				b_count_q <= q_cmd.count;
				b_fill_q  <= q_cmd.fill;
			end
			rd_q     <= src_rd;
			status_q <= src_status;
			count_q  <= src_count;
			fill_q   <= src_fill;
			last_q   <= src_last;
		end
	end

	always_ff @(posedge clk) begin
		if (issue && src_wr) begin
			mem[src_addr] <= src_wdata;
		end
		if (issue && src_rd) begin
			rdata_q <= mem[src_addr];
		end
	end

	assign out_valid  = out_valid_q;
	assign out_data   = rd_q ? rdata_q : '0;
	assign status     = status_q;
	assign out_count  = count_q;
	assign fill_level = fill_q;
	assign last       = last_q;

endmodule

FILE: tb/byte_ring_fifo_with_peek_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for byte_ring_fifo_with_peek: directed and random words are
// checked against an in-bench model of the ring, with random idling on both sides.
// Depends on brf_pkg and the byte_ring_fifo_with_peek RTL.
module byte_ring_fifo_with_peek_tb;
	import brf_pkg::*;

	localparam int RingDepth   = 1024;
	localparam int StallLimit  = 4000;
	localparam int DrainCycles = 20;
	localparam logic [2:0] OP_SPARE_LO = 3'd5;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	typedef struct {
		logic [DataW-1:0]  data;
		logic              status;
		logic [FieldW-1:0] count;
		logic [FieldW-1:0] fill;
		logic              last;
	} fifo_reply_t;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              cfg_we   = 1'b0;
	logic [CapW-1:0]   cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [2:0]        op       = '0;
	logic [DataW-1:0]  data_in  = '0;
	logic [FieldW-1:0] offset   = '0;
	logic [FieldW-1:0] amount   = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [DataW-1:0]  out_data;
	logic              status;
	logic [FieldW-1:0] out_count;
	logic [FieldW-1:0] fill_level;
	logic              last;

	logic [DataW-1:0]  ring_mem [RingDepth];
	logic [FieldW-1:0] head_ptr = '0;
	logic [FieldW-1:0] tail_ptr = '0;
	logic [CapW-1:0]   cap_reg  = CapReset;
	fifo_reply_t       fifo_replies [$];
	fifo_reply_t       oldest_reply;
	int                mismatch_count = 0;
	int                stuck_cycles   = 0;
	bit                quiet          = 1'b0;

	byte_ring_fifo_with_peek dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [CapW-1:0] ring_len();
		if (cap_reg < 2) return CapW'(2);
		if (cap_reg > RingDepth) return CapW'(RingDepth);
		return cap_reg;
	endfunction

	function automatic logic [FieldW-1:0] ring_advance(logic [FieldW-1:0] p,
			logic [FieldW-1:0] n);
		logic [CapW:0] s;
		s = p + n;
		if (s >= ring_len()) s -= ring_len();
		return s[FieldW-1:0];
	endfunction

	function automatic logic [FieldW-1:0] bytes_stored();
		logic [CapW:0] f;
		if (head_ptr >= tail_ptr) f = head_ptr - tail_ptr;
		else f = head_ptr + ring_len() - tail_ptr;
		return f[FieldW-1:0];
	endfunction

	function automatic void push_reply(logic [DataW-1:0] d, logic st, logic [FieldW-1:0] cnt,
			logic [FieldW-1:0] lvl, logic lst);
		fifo_reply_t r;
		r.data   = d;
		r.status = st;
		r.count  = cnt;
		r.fill   = lvl;
		r.last   = lst;
		fifo_replies.push_back(r);
	endfunction

	task automatic model_fifo_op(logic [2:0] code, logic [DataW-1:0] din,
			logic [FieldW-1:0] off, logic [FieldW-1:0] amt);
		logic [FieldW-1:0] lvl, n, p;
		lvl = bytes_stored();
		case (code)
			OP_WRITE: begin
				if (ring_advance(head_ptr, 1) != tail_ptr) begin
					ring_mem[head_ptr] = din;
					head_ptr = ring_advance(head_ptr, 1);
					push_reply(0, 1'b0, 0, bytes_stored(), 1'b1);
				end else begin
					push_reply(0, 1'b1, 0, lvl, 1'b1);
				end
			end
			OP_READ: begin
				if (lvl != 0) begin
					p = tail_ptr;
					tail_ptr = ring_advance(tail_ptr, 1);
					push_reply(ring_mem[p], 1'b0, 0, bytes_stored(), 1'b1);
				end else begin
					push_reply(0, 1'b1, 0, lvl, 1'b1);
				end
			end
			OP_PEEK: begin
				if (off >= lvl || amt == 0) begin
					push_reply(0, 1'b0, 0, lvl, 1'b1);
				end else begin
					n = lvl - off;
					if (amt < n) n = amt;
					if (n > MaxBurst) n = FieldW'(MaxBurst);
					p = ring_advance(tail_ptr, off);
					for (int i = 1; i <= n; i++) begin
						push_reply(ring_mem[p], 1'b0, n, lvl, i == n);
						p = ring_advance(p, 1);
					end
				end
			end
			OP_DELETE: begin
				if (lvl <= amt) begin
					tail_ptr = head_ptr;
					n = lvl;
				end else begin
					tail_ptr = ring_advance(tail_ptr, amt);
					n = amt;
				end
				push_reply(0, 1'b0, n, bytes_stored(), 1'b1);
			end
			OP_CLEAR: begin
				head_ptr = '0;
				tail_ptr = '0;
				push_reply(0, 1'b0, 0, 0, 1'b1);
			end
			default: begin
				push_reply(0, 1'b0, 0, lvl, 1'b1);
			end
		endcase
	endtask

	// Called at a rising edge; returns at the edge where the word is taken.
	task automatic send_word(logic [2:0] code, logic [DataW-1:0] din,
			logic [FieldW-1:0] off, logic [FieldW-1:0] amt);
		int gap;
		gap = 0;
		while (!quiet && $urandom_range(99) < 36) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op       <= code;
		data_in  <= din;
		offset   <= off;
		amount   <= amt;
		do @(posedge clk); while (in_stall);
		model_fifo_op(code, din, off, amt);
	endtask

	task automatic wait_for_replies();
		in_valid <= 1'b0;
		do @(negedge clk); while (fifo_replies.size() != 0);
		@(posedge clk);
	endtask

	task automatic write_capacity(logic [CapW-1:0] value);
		wait_for_replies();
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we   <= 1'b0;
		cap_reg  = value;
		head_ptr = '0;
		tail_ptr = '0;
	endtask

	// Mostly well-formed traffic: write runs to build up fill, peeks inside the stored
	// range, short deletes; the rest is full-range noise.
	task automatic run_random_mix(int words);
		logic [FieldW-1:0] lvl;
		int pick, sent, run_len;
		sent = 0;
		while (sent < words) begin
			lvl  = bytes_stored();
			pick = $urandom_range(99);
			if (pick < 6) begin
				run_len = $urandom_range(20, 90);
				if (run_len > words - sent) run_len = words - sent;
				repeat (run_len) send_word(OP_WRITE, $urandom, $urandom, $urandom);
				sent += run_len;
			end else if (pick < 45) begin
				send_word(OP_WRITE, $urandom, $urandom, $urandom);
				sent++;
			end else if (pick < 62) begin
				send_word(OP_READ, $urandom, $urandom, $urandom);
				sent++;
			end else if (pick < 84) begin
				send_word(OP_PEEK, $urandom,
					(lvl != 0 && $urandom_range(99) < 80) ? $urandom_range(lvl - 1) : $urandom,
					($urandom_range(99) < 85) ? $urandom_range(1, 80) : $urandom);
				sent++;
			end else if (pick < 94) begin
				send_word(OP_DELETE, $urandom, $urandom,
					($urandom_range(99) < 80) ? $urandom_range(8) : $urandom);
				sent++;
			end else if (pick < 96) begin
				send_word(OP_CLEAR, $urandom, $urandom, $urandom);
				sent++;
			end else begin
				send_word($urandom_range(OP_SPARE_HI, OP_SPARE_LO), $urandom, $urandom, $urandom);
				sent++;
			end
		end
	endtask

	task automatic test_basic_ops();
		send_word(OP_READ, 8'hFF, '1, '1);
		send_word(OP_PEEK, 8'h00, '0, 10'd1);
		send_word(OP_WRITE, 8'h00, '0, '0);
		send_word(OP_WRITE, 8'hFF, '1, '1);
		send_word(OP_WRITE, 8'h5A, '0, '0);
		send_word(OP_WRITE, 8'hA5, '0, '0);
		send_word(OP_PEEK, 8'h00, '0, '1);
		send_word(OP_PEEK, 8'h00, 10'd1, 10'd2);
		send_word(OP_PEEK, 8'h00, 10'd4, 10'd1);
		send_word(OP_PEEK, 8'h00, '1, 10'd5);
		send_word(OP_PEEK, 8'h00, '0, '0);
		send_word(OP_DELETE, 8'h00, '0, 10'd1);
		send_word(OP_READ, 8'h00, '0, '0);
		send_word(OP_DELETE, 8'h00, '0, '0);
		send_word(OP_DELETE, 8'h00, '0, '1);
		for (int c = OP_SPARE_LO; c <= OP_SPARE_HI; c++) send_word(3'(c), 8'hFF, '1, '1);
		send_word(OP_WRITE, 8'h3C, '0, '0);
		send_word(OP_CLEAR, 8'h00, '0, '0);
		send_word(OP_READ, 8'h00, '0, '0);
	endtask

	// Capacity below the legal range works as a two-slot ring holding one byte.
	task automatic test_capacity_clamp();
		write_capacity('0);
		send_word(OP_WRITE, 8'h81, '0, '0);
		send_word(OP_WRITE, 8'h7E, '0, '0);
		send_word(OP_PEEK, 8'h00, '0, '1);
		send_word(OP_READ, 8'h00, '0, '0);
		send_word(OP_READ, 8'h00, '0, '0);
	endtask

	task automatic test_full_depth_mix();
		write_capacity('1);
		run_random_mix(70);
	endtask

	task automatic test_small_ring_mix();
		write_capacity($urandom_range(3, 12));
		run_random_mix(50);
	endtask

	task automatic test_drain_pause();
		write_capacity($urandom_range(40, 200));
		run_random_mix(20);
		wait_for_replies();
		run_random_mix(20);
	endtask

	task automatic test_back_to_back();
		write_capacity($urandom_range(2, RingDepth));
		quiet = 1'b1;
		run_random_mix(50);
		quiet = 1'b0;
	endtask

	task automatic test_reset_capacity();
		write_capacity(CapReset);
		run_random_mix(40);
	endtask

	function automatic void check_field(string name, logic [FieldW-1:0] want,
			logic [FieldW-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (fifo_replies.size() == 0) begin
				$error("unexpected word: out_data %0d fill_level %0d", out_data, fill_level);
				mismatch_count++;
			end else begin
				oldest_reply = fifo_replies.pop_front();
				check_field("out_data", oldest_reply.data, out_data);
				check_field("status", oldest_reply.status, status);
				check_field("out_count", oldest_reply.count, out_count);
				check_field("fill_level", oldest_reply.fill, fill_level);
				check_field("last", oldest_reply.last, last);
			end
		end
		out_stall <= arst_n && !quiet && ($urandom_range(99) < 36);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles <= 0;
		else stuck_cycles <= stuck_cycles + 1;
	end

	initial begin
		wait (stuck_cycles >= StallLimit);
		$error("no word moved for %0d cycles", StallLimit);
		$display("FAIL");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_basic_ops();
		test_capacity_clamp();
		test_full_depth_mix();
		test_small_ring_mix();
		test_drain_pause();
		test_back_to_back();
		test_reset_capacity();
		wait_for_replies();
		repeat (DrainCycles) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

FILE: byte_ring_fifo_with_peek.f
src/brf_pkg.sv
src/brf_front.sv
src/brf_queue.sv
src/brf_back.sv
src/byte_ring_fifo_with_peek.sv
tb/byte_ring_fifo_with_peek_tb.sv
